// File: design/tsa_pkg.sv
// Shared types, widths and codes for the multi-input timeslot aligner.
package tsa_pkg;

   localparam int MAX_INPUTS_DEF = 16;
   localparam int SLOT_BITS_DEF  = 64;

   localparam int STAMP_W      = 64;
   localparam int INDEX_W      = 4;
   localparam int DIVISOR_W    = 32;
   localparam int ACTIVE_W     = 5;
   localparam int CLOCK_SLOT_W = 64;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 72;

   localparam logic CMD_UPDATE  = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_DIVISOR  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_INPUTS = 4'd1;

   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 32'd1000000000;
   localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 5'd1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_REFUSED   = 2'd1,
      ST_BACKWARDS = 2'd2
   } status_type;

   typedef struct packed {
      logic latch_req;
      logic cnt_clear;
      logic cnt_step;
      logic div_step;
      logic rd_idx;
      logic rd_scan;
      logic apply_upd;
      logic apply_adv;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic adv_ready;
      logic div_last;
      logic scan_last;
      logic out_free;
   } ctl_stat_type;

endpackage

// File: design/multi_input_timeslot_aligner.sv
// Top level of the multi-input timeslot aligner.
// One item is processed at a time. An update captures the item, runs the bit-serial stamp
// divider, then does the slot check and write, a store read-back and the result load. An
// advance reads the store once per input to find the minimum and applies it when every
// active input holds a slot; either way it ends with a read-back and the result load.
// The active input count is active_inputs clamped to MAX_INPUTS. A new item is taken once
// the previous one has been loaded into the result register, even while that result still
// waits for rsp_tready. Input slots live in a RAM and are defined only once written; their
// valid bits clear at reset, so no clearing pass is needed. Writes to csr_index values other
// than 0 (slot_divisor) and 1 (active_inputs) are ignored.
module multi_input_timeslot_aligner #(
   parameter int MAX_INPUTS = tsa_pkg::MAX_INPUTS_DEF,
   parameter int SLOT_BITS  = tsa_pkg::SLOT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // input_sel[3:0], stamp[67:4], zero[71:68]
   input  logic [tsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], advanced[2], clock_valid[3], clock_slot[67:4],
   // input_current[68], input_may_update[69], zero[71:70]
   output logic [tsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tsa_pkg::*;

   ctl_cmd_type                cmd;
   ctl_stat_type               stat;
   status_type                 rsp_status;
   logic                       rsp_advanced;
   logic                       rsp_clock_valid;
   logic [CLOCK_SLOT_W-1:0]    rsp_clock_slot;
   logic                       rsp_input_current;
   logic                       rsp_input_may_update;

   assign csr_ready = 1'b1;

   tsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .stat        (stat),
      .cmd         (cmd)
   );

   tsa_datapath #(
      .MAX_INPUTS (MAX_INPUTS),
      .SLOT_BITS  (SLOT_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_index            (req_tdata[INDEX_W-1:0]),
      .req_stamp            (req_tdata[INDEX_W+STAMP_W-1:INDEX_W]),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_tready           (rsp_tready),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_status           (rsp_status),
      .rsp_advanced         (rsp_advanced),
      .rsp_clock_valid      (rsp_clock_valid),
      .rsp_clock_slot       (rsp_clock_slot),
      .rsp_input_current    (rsp_input_current),
      .rsp_input_may_update (rsp_input_may_update)
   );

   assign rsp_tdata = {2'b00, rsp_input_may_update, rsp_input_current, rsp_clock_slot,
                       rsp_clock_valid, rsp_advanced, rsp_status};

endmodule

// File: design/tsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tsa_ctrl.sv
// Sequencing state machine for update and advance items.
module tsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_command,
   input  tsa_pkg::ctl_stat_type  stat,
   output tsa_pkg::ctl_cmd_type   cmd
);
   import tsa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DIV      = 8'b0000_0010,
      S_UPD      = 8'b0000_0100,
      S_SCAN     = 8'b0000_1000,
      S_SCAN_END = 8'b0001_0000,
      S_ADV      = 8'b0010_0000,
      S_FLRD     = 8'b0100_0000,
      S_FLAG     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               cmd.cnt_clear = 1'b1;
               if (req_command == CMD_ADVANCE) begin
                  state_in = stat.adv_ready ? S_SCAN : S_FLRD;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.rd_idx   = 1'b1;
            cmd.cnt_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.apply_upd = 1'b1;
            state_in      = S_FLRD;
         end
         S_SCAN: begin
            cmd.rd_scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_SCAN_END;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         S_SCAN_END: begin
            state_in = S_ADV;
         end
         S_ADV: begin
            cmd.apply_adv = 1'b1;
            state_in      = S_FLRD;
         end
         S_FLRD: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_FLAG;
         end
         S_FLAG: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/tsa_datapath.sv
// Datapath: config registers, slot store, divider, minimum scan and result register.
module tsa_datapath #(
   parameter int MAX_INPUTS = tsa_pkg::MAX_INPUTS_DEF,
   parameter int SLOT_BITS  = tsa_pkg::SLOT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [tsa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [tsa_pkg::INDEX_W-1:0]         req_index,
   input  logic [tsa_pkg::STAMP_W-1:0]         req_stamp,
   input  tsa_pkg::ctl_cmd_type                cmd,
   output tsa_pkg::ctl_stat_type               stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output tsa_pkg::status_type                 rsp_status,
   output logic                                rsp_advanced,
   output logic                                rsp_clock_valid,
   output logic [tsa_pkg::CLOCK_SLOT_W-1:0]    rsp_clock_slot,
   output logic                                rsp_input_current,
   output logic                                rsp_input_may_update
);
   import tsa_pkg::*;

   localparam int ADDR_W   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int LIVE_W   = $clog2(MAX_INPUTS + 1);
   localparam int DCNT_W   = $clog2(STAMP_W);
   localparam int CNT_W    = (ADDR_W > DCNT_W) ? ADDR_W : DCNT_W;

   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [ACTIVE_W-1:0]   active_ff, active_in;
   logic [MAX_INPUTS-1:0] valid_ff, valid_in;
   logic [SLOT_BITS-1:0]  shared_ff, shared_in;
   logic                  shared_valid_ff, shared_valid_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [STAMP_W-1:0]    dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  scan_vld_ff, scan_vld_in;
   logic                  scan_first_ff, scan_first_in;
   logic [SLOT_BITS-1:0]  lowest_ff, lowest_in;
   status_type            status_ff, status_in;
   logic                  moved_ff, moved_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_advanced_ff, rsp_advanced_in;
   logic                  rsp_clock_valid_ff, rsp_clock_valid_in;
   logic [CLOCK_SLOT_W-1:0] rsp_clock_slot_ff, rsp_clock_slot_in;
   logic                  rsp_current_ff, rsp_current_in;
   logic                  rsp_may_ff, rsp_may_in;

   logic [LIVE_W-1:0]     live;
   logic [ADDR_W-1:0]     idx_a;
   logic [ADDR_W-1:0]     scan_a;
   logic                  in_range;
   logic                  idx_valid;
   logic                  slot_match;
   logic                  all_set;
   logic [DIVISOR_W:0]    div_shift;
   logic [DIVISOR_W+1:0]  div_diff;
   logic                  div_ge;
   logic                  q_over;
   logic [SLOT_BITS-1:0]  q_sat;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [SLOT_BITS-1:0]  ram_rd_data;

   tsa_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (MAX_INPUTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_a),
      .wr_data (q_sat),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign live = (32'(active_ff) > MAX_INPUTS) ? LIVE_W'(MAX_INPUTS) : LIVE_W'(active_ff);
   assign idx_a     = ADDR_W'(idx_ff);
   assign scan_a    = ADDR_W'(cnt_ff);
   assign in_range  = (32'(idx_ff) < 32'(live));
   assign idx_valid = in_range && valid_ff[idx_a];
   assign slot_match = in_range && (idx_valid == shared_valid_ff)
                       && (!idx_valid || (ram_rd_data == shared_ff));

   assign div_shift = {rem_ff, dvd_ff[STAMP_W-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_ff};
   assign div_ge    = !div_diff[DIVISOR_W+1];

   assign q_over = ((dvd_ff >> SLOT_BITS) != '0);
   assign q_sat  = ((divisor_ff == '0) || q_over) ? '1 : dvd_ff[SLOT_BITS-1:0];

   assign ram_rd_en   = cmd.rd_idx || cmd.rd_scan;
   assign ram_rd_addr = cmd.rd_scan ? scan_a : idx_a;

   always_comb begin
      all_set = 1'b1;
      for (int i = 0; i < MAX_INPUTS; i++) begin
         if ((i < int'(live)) && !valid_ff[i]) begin
            all_set = 1'b0;
         end
      end
   end

   assign stat.adv_ready = (live != '0) && all_set;
   assign stat.div_last  = (cnt_ff == CNT_W'(STAMP_W - 1));
   assign stat.scan_last = ((32'(cnt_ff) + 1) == 32'(live));
   assign stat.out_free  = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      divisor_in         = divisor_ff;
      active_in          = active_ff;
      valid_in           = valid_ff;
      shared_in          = shared_ff;
      shared_valid_in    = shared_valid_ff;
      idx_in             = idx_ff;
      dvd_in             = dvd_ff;
      rem_in             = rem_ff;
      cnt_in             = cnt_ff;
      lowest_in          = lowest_ff;
      status_in          = status_ff;
      moved_in           = moved_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_advanced_in    = rsp_advanced_ff;
      rsp_clock_valid_in = rsp_clock_valid_ff;
      rsp_clock_slot_in  = rsp_clock_slot_ff;
      rsp_current_in     = rsp_current_ff;
      rsp_may_in         = rsp_may_ff;
      rsp_tvalid_in      = rsp_tvalid_ff;
      ram_wr_en          = 1'b0;
      scan_vld_in        = cmd.rd_scan;
      scan_first_in      = cmd.rd_scan && (cnt_ff == '0);

      if (csr_write) begin
         unique case (csr_index)
            CSR_SLOT_DIVISOR:  divisor_in = csr_data[DIVISOR_W-1:0];
            CSR_ACTIVE_INPUTS: active_in  = csr_data[ACTIVE_W-1:0];
            default: ;
         endcase
      end

      if (cmd.latch_req) begin
         idx_in    = req_index;
         dvd_in    = req_stamp;
         rem_in    = '0;
         status_in = ST_OK;
         moved_in  = 1'b0;
      end

      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_step) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.div_step) begin
         rem_in = div_ge ? div_diff[DIVISOR_W-1:0] : div_shift[DIVISOR_W-1:0];
         dvd_in = {dvd_ff[STAMP_W-2:0], div_ge};
      end

      if (scan_vld_ff) begin
         if (scan_first_ff || (ram_rd_data < lowest_ff)) begin
            lowest_in = ram_rd_data;
         end
      end

      if (cmd.apply_upd) begin
         if (!slot_match) begin
            status_in = ST_REFUSED;
         end else if (idx_valid && (q_sat < ram_rd_data)) begin
            status_in = ST_BACKWARDS;
         end else begin
            status_in        = ST_OK;
            ram_wr_en        = 1'b1;
            valid_in[idx_a]  = 1'b1;
         end
      end

      if (cmd.apply_adv) begin
         if (!shared_valid_ff) begin
            shared_in       = lowest_ff;
            shared_valid_in = 1'b1;
         end else if (lowest_ff > shared_ff) begin
            shared_in = lowest_ff;
            moved_in  = 1'b1;
         end
      end

      if (cmd.load_out) begin
         rsp_tvalid_in      = 1'b1;
         rsp_status_in      = status_ff;
         rsp_advanced_in    = moved_ff;
         rsp_clock_valid_in = shared_valid_ff;
         rsp_clock_slot_in  = shared_valid_ff ? CLOCK_SLOT_W'(shared_ff) : '0;
         rsp_may_in         = slot_match;
         rsp_current_in     = slot_match && shared_valid_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff      <= DIVISOR_RESET;
         active_ff       <= ACTIVE_RESET;
         valid_ff        <= '0;
         shared_ff       <= '0;
         shared_valid_ff <= 1'b0;
         scan_vld_ff     <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         divisor_ff      <= divisor_in;
         active_ff       <= active_in;
         valid_ff        <= valid_in;
         shared_ff       <= shared_in;
         shared_valid_ff <= shared_valid_in;
         scan_vld_ff     <= scan_vld_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff             <= idx_in;
      dvd_ff             <= dvd_in;
      rem_ff             <= rem_in;
      cnt_ff             <= cnt_in;
      scan_first_ff      <= scan_first_in;
      lowest_ff          <= lowest_in;
      status_ff          <= status_in;
      moved_ff           <= moved_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_advanced_ff    <= rsp_advanced_in;
      rsp_clock_valid_ff <= rsp_clock_valid_in;
      rsp_clock_slot_ff  <= rsp_clock_slot_in;
      rsp_current_ff     <= rsp_current_in;
      rsp_may_ff         <= rsp_may_in;
   end

   assign rsp_tvalid           = rsp_tvalid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_advanced         = rsp_advanced_ff;
   assign rsp_clock_valid      = rsp_clock_valid_ff;
   assign rsp_clock_slot       = rsp_clock_slot_ff;
   assign rsp_input_current    = rsp_current_ff;
   assign rsp_input_may_update = rsp_may_ff;

`ifndef NO_ASSERTIONS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten before transfer");

   a_clock_sticky: assert property (@(posedge clock) disable iff (reset)
      shared_valid_ff |=> shared_valid_ff)
      else $error("current slot lost its valid flag");

   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      shared_valid_ff |=> (shared_ff >= $past(shared_ff)))
      else $error("current slot moved backwards");

   a_moved_needs_clock: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_advanced_ff) |-> (rsp_clock_valid_ff && rsp_current_ff == 1'b0
         || rsp_clock_valid_ff))
      else $error("advance reported without a valid current slot");

   a_current_implies_may: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_current_ff) |-> (rsp_may_ff && rsp_clock_valid_ff))
      else $error("input reported current without matching slot");
`endif

endmodule
